// ----- rtl/chda_pkg.sv -----
// Shared types and constants for the compass heading unit.
// Holds the vector beat type, the micro-rotation angle table and the scaling constants.
// No dependencies.
package chda_pkg;

    localparam int unsigned ANGLE_ITERATIONS_DEF = 16;
    localparam int unsigned TABLE_LEN            = 24;

    localparam int unsigned IN_W        = 16;
    localparam int unsigned COORD_SHIFT = 26;
    localparam int unsigned COORD_W     = 45;
    localparam int unsigned Z_W         = 41;
    localparam int unsigned OUT_W       = 16;

    localparam logic signed [Z_W-1:0] DEG180_NDEG = 41'sd180000000000;
    localparam logic signed [Z_W-1:0] DEG360_NDEG = 41'sd360000000000;
    localparam logic signed [Z_W-1:0] HALF_CDEG   = 41'sd5000000;

    localparam int unsigned DIV_SHIFT   = 7;
    localparam int unsigned A_W         = 32;
    localparam int unsigned RECIP_SHIFT = 48;
    localparam int unsigned PROD_W      = 64;
    localparam int unsigned REM_W       = 33;
    localparam logic [A_W-1:0]   RECIP      = 32'd3602879701;
    localparam logic [REM_W-1:0] DIV_ODD    = 33'd78125;
    localparam logic [OUT_W-1:0] FULL_TURN  = 16'd36000;

    localparam logic signed [Z_W-1:0] ATAN_NDEG [TABLE_LEN] = '{
        41'sd45000000000, 41'sd26565051177, 41'sd14036243468, 41'sd7125016349,
        41'sd3576334375,  41'sd1789910608,  41'sd895173710,   41'sd447614171,
        41'sd223810500,   41'sd111905677,   41'sd55952892,    41'sd27976453,
        41'sd13988227,    41'sd6994114,     41'sd3497057,     41'sd1748528,
        41'sd874264,      41'sd437132,      41'sd218566,      41'sd109283,
        41'sd54642,       41'sd27321,       41'sd13660,       41'sd6830
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [Z_W-1:0]     z;
        logic                      zero;
    } t_vec;

endpackage

// ----- rtl/chda_fold.sv -----
// Entry stage: folds the left half plane onto the right one and scales the counts.
// Depends on chda_pkg.
module chda_fold
    import chda_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [IN_W-1:0] i_mag_x,
    input  logic signed [IN_W-1:0] i_mag_y,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_vec                   o_vec
);

    logic        r_valid;
    t_vec        r_vec;
    t_vec        n_vec;
    logic        neg;
    logic [IN_W:0] xf;
    logic [IN_W:0] yf;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_vec   = r_vec;

    always_comb begin
        neg = i_mag_x[IN_W-1];
        xf  = neg ? -{i_mag_x[IN_W-1], i_mag_x} : {i_mag_x[IN_W-1], i_mag_x};
        yf  = neg ? -{i_mag_y[IN_W-1], i_mag_y} : {i_mag_y[IN_W-1], i_mag_y};
        n_vec.x    = {{(COORD_W-IN_W-1-COORD_SHIFT){xf[IN_W]}}, xf, {COORD_SHIFT{1'b0}}};
        n_vec.y    = {{(COORD_W-IN_W-1-COORD_SHIFT){yf[IN_W]}}, yf, {COORD_SHIFT{1'b0}}};
        n_vec.z    = neg ? DEG180_NDEG : '0;
        n_vec.zero = (i_mag_x == '0) && (i_mag_y == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_vec <= n_vec;
        end
    end

endmodule

// ----- rtl/chda_rot_stage.sv -----
// One registered vectoring micro-rotation with a fixed shift.
// Depends on chda_pkg.
module chda_rot_stage
    import chda_pkg::*;
#(
    parameter int unsigned SHIFT = 0
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_vec i_vec,
    output logic o_valid,
    input  logic i_ready,
    output t_vec o_vec
);

    logic                      r_valid;
    t_vec                      r_vec;
    t_vec                      n_vec;
    logic signed [COORD_W-1:0] xv;
    logic signed [COORD_W-1:0] yv;
    logic signed [COORD_W-1:0] xs;
    logic signed [COORD_W-1:0] ys;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_vec   = r_vec;

    always_comb begin
        xv = i_vec.x;
        yv = i_vec.y;
        xs = xv >>> SHIFT;
        ys = yv >>> SHIFT;
        n_vec.zero = i_vec.zero;
        if (!yv[COORD_W-1]) begin
            n_vec.x = xv + ys;
            n_vec.y = yv - xs;
            n_vec.z = i_vec.z + ATAN_NDEG[SHIFT];
        end else begin
            n_vec.x = xv - ys;
            n_vec.y = yv + xs;
            n_vec.z = i_vec.z - ATAN_NDEG[SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_vec <= n_vec;
        end
    end

endmodule

// ----- rtl/chda_post.sv -----
// Four-stage back end: wraps the angle, rounds to hundredths of a degree through a
// reciprocal multiply with one correction step, and wraps a full turn. Depends on chda_pkg.
module chda_post
    import chda_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_vec             i_vec,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_heading
);

    logic [3:0]              r_valid;
    logic [3:0]              rdy;

    logic [A_W-1:0]          r_a1;
    logic                    r_zero1;
    logic [A_W-1:0]          r_a2;
    logic [OUT_W-1:0]        r_q2;
    logic                    r_zero2;
    logic [A_W-1:0]          r_a3;
    logic [OUT_W-1:0]        r_q3;
    logic [REM_W-1:0]        r_p3;
    logic                    r_zero3;
    logic [OUT_W-1:0]        r_heading;

    logic signed [Z_W-1:0]   tot;
    logic signed [Z_W-1:0]   rnd;
    logic [A_W-1:0]          n_a1;
    logic [PROD_W-1:0]       prod;
    logic [OUT_W-1:0]        n_q2;
    logic [REM_W-1:0]        n_p3;
    logic [REM_W-1:0]        rem;
    logic [OUT_W-1:0]        qc;
    logic [OUT_W-1:0]        n_heading;

    assign rdy[3]    = !r_valid[3] || i_ready;
    assign rdy[2]    = !r_valid[2] || rdy[3];
    assign rdy[1]    = !r_valid[1] || rdy[2];
    assign rdy[0]    = !r_valid[0] || rdy[1];
    assign o_ready   = rdy[0];
    assign o_valid   = r_valid[3];
    assign o_heading = r_heading;

    always_comb begin
        tot = i_vec.z[Z_W-1] ? i_vec.z + DEG360_NDEG : i_vec.z;
        if (tot[Z_W-1]) begin
            tot = '0;
        end
        rnd  = tot + HALF_CDEG;
        n_a1 = rnd[DIV_SHIFT +: A_W];

        prod = PROD_W'(r_a1) * PROD_W'(RECIP);
        n_q2 = prod[RECIP_SHIFT +: OUT_W];

        n_p3 = REM_W'(r_q2) * DIV_ODD;

        rem = REM_W'(r_a3) - r_p3;
        qc  = (rem >= DIV_ODD) ? r_q3 + OUT_W'(1) : r_q3;
        if (qc >= FULL_TURN) begin
            qc = qc - FULL_TURN;
        end
        n_heading = r_zero3 ? '0 : qc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (rdy[0]) begin
                r_valid[0] <= i_valid;
            end
            if (rdy[1]) begin
                r_valid[1] <= r_valid[0];
            end
            if (rdy[2]) begin
                r_valid[2] <= r_valid[1];
            end
            if (rdy[3]) begin
                r_valid[3] <= r_valid[2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r_a1    <= n_a1;
            r_zero1 <= i_vec.zero;
        end
        if (rdy[1] && r_valid[0]) begin
            r_a2    <= r_a1;
            r_q2    <= n_q2;
            r_zero2 <= r_zero1;
        end
        if (rdy[2] && r_valid[1]) begin
            r_a3    <= r_a2;
            r_q3    <= r_q2;
            r_p3    <= n_p3;
            r_zero3 <= r_zero2;
        end
        if (rdy[3] && r_valid[2]) begin
            r_heading <= n_heading;
        end
    end

endmodule

// ----- rtl/compass_heading_atan2_unit.sv -----
// Compass heading unit: atan2(Y, X) of a magnetometer sample in hundredths of a degree.
// The pipeline has one fold stage, one stage per micro-rotation
// (capped at 24) and four rounding stages. Throughput is one beat per cycle; every stage
// holds its beat only while the stage after it is full and stalled.
// Reset (synchronous, active low) empties the pipeline; data registers are not cleared.
// Depends on chda_pkg, chda_fold, chda_rot_stage and chda_post.
module compass_heading_atan2_unit
    import chda_pkg::*;
#(
    parameter int unsigned ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [IN_W-1:0] i_mag_x,
    input  logic signed [IN_W-1:0] i_mag_y,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [OUT_W-1:0]       o_heading_centideg
);

    localparam int unsigned STAGES =
        (ANGLE_ITERATIONS < TABLE_LEN) ? ANGLE_ITERATIONS : TABLE_LEN;

    t_vec vec [STAGES+1];
    logic vld [STAGES+1];
    logic rdy [STAGES+1];
    logic in_ready;

    assign o_stall = !in_ready;

    chda_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (in_ready),
        .i_mag_x (i_mag_x),
        .i_mag_y (i_mag_y),
        .o_valid (vld[0]),
        .i_ready (rdy[0]),
        .o_vec   (vec[0])
    );

    for (genvar k = 0; k < STAGES; k++) begin : g_rot
        chda_rot_stage #(
            .SHIFT (k)
        ) u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[k]),
            .o_ready (rdy[k]),
            .i_vec   (vec[k]),
            .o_valid (vld[k+1]),
            .i_ready (rdy[k+1]),
            .o_vec   (vec[k+1])
        );
    end

    chda_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (vld[STAGES]),
        .o_ready   (rdy[STAGES]),
        .i_vec     (vec[STAGES]),
        .o_valid   (o_valid),
        .i_ready   (!i_stall),
        .o_heading (o_heading_centideg)
    );

endmodule

// ----- tb/sv/compass_heading_atan2_unit_test.sv -----
// Self-checking testbench for compass_heading_atan2_unit: drives magnetometer samples
// under random idling and stalls and checks every heading against an internal CORDIC predictor.
// Depends on chda_pkg and compass_heading_atan2_unit.
module compass_heading_atan2_unit_test;
    import chda_pkg::*;

    localparam int unsigned ROT_STEPS      = 16;
    localparam int          WATCHDOG_LIMIT = 2000;

    localparam longint ROT_ANGLE_NDEG [24] = '{
        64'sd45000000000, 64'sd26565051177, 64'sd14036243468, 64'sd7125016349,
        64'sd3576334375,  64'sd1789910608,  64'sd895173710,   64'sd447614171,
        64'sd223810500,   64'sd111905677,   64'sd55952892,    64'sd27976453,
        64'sd13988227,    64'sd6994114,     64'sd3497057,     64'sd1748528,
        64'sd874264,      64'sd437132,      64'sd218566,      64'sd109283,
        64'sd54642,       64'sd27321,       64'sd13660,       64'sd6830
    };

    class heading_scoreboard;
        logic [OUT_W-1:0] expected_headings [$];
        int               mismatches;
        int               samples_seen;
        int               headings_checked;

        function logic [OUT_W-1:0] predict_heading(logic signed [IN_W-1:0] mx,
                                                   logic signed [IN_W-1:0] my);
            longint px;
            longint py;
            longint ang;
            longint sx;
            longint sy;
            longint cdeg;
            px  = mx;
            py  = my;
            ang = 0;
            if (px == 0 && py == 0) begin
                return '0;
            end
            if (px < 0) begin
                px  = -px;
                py  = -py;
                ang = 64'sd180000000000;
            end
            px = px <<< 26;
            py = py <<< 26;
            for (int i = 0; i < ROT_STEPS && i < 24; i++) begin
                sx = px >>> i;
                sy = py >>> i;
                if (py >= 0) begin
                    px  = px + sy;
                    py  = py - sx;
                    ang = ang + ROT_ANGLE_NDEG[i];
                end else begin
                    px  = px - sy;
                    py  = py + sx;
                    ang = ang - ROT_ANGLE_NDEG[i];
                end
            end
            if (ang < 0) begin
                ang = ang + 64'sd360000000000;
            end
            if (ang < 0) begin
                ang = 0;
            end
            cdeg = (ang + 5000000) / 10000000;
            if (cdeg >= 36000) begin
                cdeg = cdeg - 36000;
            end
            if (cdeg >= 36000) begin
                cdeg = 0;
            end
            return cdeg[OUT_W-1:0];
        endfunction

        function void note_sample(logic signed [IN_W-1:0] mx, logic signed [IN_W-1:0] my);
            expected_headings.push_back(predict_heading(mx, my));
            samples_seen++;
        endfunction

        function void check_heading(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            headings_checked++;
            if (expected_headings.size() == 0) begin
                $error("heading_centideg: no beat expected, actual %0d", got);
                mismatches++;
                return;
            end
            want = expected_headings.pop_front();
            if (got !== want) begin
                $error("heading_centideg: expected %0d, actual %0d", want, got);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_headings.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic signed [IN_W-1:0] i_mag_x;
    logic signed [IN_W-1:0] i_mag_y;
    logic                   o_valid;
    logic                   i_stall;
    logic [OUT_W-1:0]       o_heading_centideg;

    heading_scoreboard sb;
    bit                no_gaps;
    int                idle_cycles;

    compass_heading_atan2_unit #(
        .ANGLE_ITERATIONS (ROT_STEPS)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_mag_x            (i_mag_x),
        .i_mag_y            (i_mag_y),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_heading_centideg (o_heading_centideg)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_sample(i_mag_x, i_mag_y);
            end
            if (o_valid && !i_stall) begin
                sb.check_heading(o_heading_centideg);
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function int draw_wait();
        return no_gaps ? 0 : int'($urandom_range(0, 14));
    endfunction

    // Consumer side: stall for a random number of cycles, then take one beat.
    initial begin
        int stall_cycles;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall_cycles = draw_wait();
            if (stall_cycles > 0) begin
                @(negedge i_clk) i_stall = 1'b1;
                repeat (stall_cycles - 1) @(negedge i_clk);
                @(negedge i_clk) i_stall = 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    task automatic send_sample(input logic signed [IN_W-1:0] mx,
                               input logic signed [IN_W-1:0] my);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            @(negedge i_clk) i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_mag_x = mx;
        i_mag_y = my;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_sample();
        logic signed [IN_W-1:0] rx;
        logic signed [IN_W-1:0] ry;
        logic signed [IN_W-1:0] edges [5];
        int kind;
        edges = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001};
        kind  = int'($urandom_range(0, 9));
        rx    = IN_W'($urandom());
        ry    = IN_W'($urandom());
        if (kind == 6 || kind == 7) begin
            rx = $signed(IN_W'($urandom_range(0, 16))) - 16'sd8;
            ry = $signed(IN_W'($urandom_range(0, 16))) - 16'sd8;
        end else if (kind == 8) begin
            ry = $signed(IN_W'($urandom_range(0, 6))) - 16'sd3;
            if ($urandom_range(0, 1) == 1) begin
                {rx, ry} = {ry, rx};
            end
        end else if (kind == 9) begin
            rx = edges[$urandom_range(0, 4)];
            ry = edges[$urandom_range(0, 4)];
        end
        send_sample(rx, ry);
    endtask

    initial begin
        sb          = new();
        no_gaps     = 1'b0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_mag_x     = '0;
        i_mag_y     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd1, 16'sd0);
        send_sample(16'sd0, 16'sd1);
        send_sample(-16'sd1, 16'sd0);
        send_sample(16'sd0, -16'sd1);
        send_sample(16'sd32767, 16'sd0);
        send_sample(-16'sd32768, 16'sd0);
        send_sample(16'sd0, 16'sd32767);
        send_sample(16'sd0, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd1, 16'sd1);
        send_sample(-16'sd1, 16'sd1);
        send_sample(-16'sd1, -16'sd1);
        send_sample(16'sd1, -16'sd1);
        send_sample(16'sd32767, -16'sd1);
        send_sample(16'sd32767, 16'sd1);
        send_sample(-16'sd32768, 16'sd1);
        send_sample(-16'sd32768, -16'sd1);
        send_sample(-16'sd1, -16'sd32768);
        send_sample(16'sd12345, -16'sd23456);

        @(negedge i_clk) i_valid = 1'b0;
        wait_drained();

        for (int seg = 0; seg < 9; seg++) begin
            no_gaps = (seg % 3 == 1);
            repeat (50) send_random_sample();
        end

        @(negedge i_clk) i_valid = 1'b0;
        wait_drained();
        repeat (ROT_STEPS + 10) @(posedge i_clk);

        $display("Covered %0d samples: axes, extremes, zero vector, all four quadrants.",
                 sb.samples_seen);
        $display("Checked %0d headings with %0d mismatches.", sb.headings_checked,
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/chda_pkg.sv
rtl/chda_fold.sv
rtl/chda_rot_stage.sv
rtl/chda_post.sv
rtl/compass_heading_atan2_unit.sv
tb/sv/compass_heading_atan2_unit_test.sv
